>>> rtl/core/wrist_sleep_stage_tracker_assert.svh
// assertion macros for the sleep stage tracker
`ifndef WRIST_SLEEP_STAGE_TRACKER_ASSERT_SVH
`define WRIST_SLEEP_STAGE_TRACKER_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define WSST_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("wsst invariant violated");

// consequent that must hold in the cycle after the antecedent
`define WSST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wsst sequence violated");

`endif

>>> rtl/core/wsst_pkg.sv
`default_nettype none

package wsst_pkg;

   // early hours that keep a motion flag each
   localparam int MOTION_HOURS = 6;

   // field widths
   localparam int ACCEL_WIDTH  = 16;
   localparam int SUM_WIDTH    = ACCEL_WIDTH + 2;
   localparam int MAG_WIDTH    = 17;
   localparam int STEP_WIDTH   = 24;
   localparam int HR_WIDTH     = 8;
   localparam int HOUR_WIDTH   = 5;
   localparam int STILL_WIDTH  = 16;
   localparam int PHASE_WIDTH  = 6;
   localparam int EMPTY_WIDTH  = 3;
   localparam int AWAKE_WIDTH  = 9;
   localparam int TOTAL_WIDTH  = 16;
   localparam int SCALED_WIDTH = 17;
   localparam int AWAKE_LIMIT_WIDTH = 8;
   localparam int ZERO_COUNT_WIDTH  = $clog2(MOTION_HOURS + 1);

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 17;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MOVE_THRESHOLD     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVITY_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIGHT_STILL        = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEEP_STILL         = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONWEAR_STILL      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AWAKE_LIMIT        = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EMPTY_HOUR_LIMIT   = 3'd6;

   // register reset values
   localparam logic [MAG_WIDTH-1:0]         MOVE_THRESHOLD_RESET     = 17'd100;
   localparam logic [MAG_WIDTH-1:0]         ACTIVITY_THRESHOLD_RESET = 17'd200;
   localparam logic [STILL_WIDTH-1:0]       LIGHT_STILL_RESET        = 16'd60;
   localparam logic [STILL_WIDTH-1:0]       DEEP_STILL_RESET         = 16'd600;
   localparam logic [STILL_WIDTH-1:0]       NONWEAR_STILL_RESET      = 16'd7200;
   localparam logic [AWAKE_LIMIT_WIDTH-1:0] AWAKE_LIMIT_RESET        = 8'd180;
   localparam logic [EMPTY_WIDTH-1:0]       EMPTY_HOUR_LIMIT_RESET   = 3'd3;

   // clock hours and minute tick
   localparam logic [HOUR_WIDTH-1:0]  NIGHT_START_HOUR  = 5'd20;
   localparam logic [HOUR_WIDTH-1:0]  MORNING_HOUR      = 5'd8;
   localparam logic [HOUR_WIDTH-1:0]  MOTION_HOURS_HOUR = HOUR_WIDTH'(MOTION_HOURS);
   localparam logic [PHASE_WIDTH-1:0] PHASE_LAST        = 6'd59;

   // saturation limits
   localparam logic [STILL_WIDTH-1:0] STILL_MAX = '1;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;
   localparam logic [AWAKE_WIDTH-1:0] AWAKE_MAX = '1;
   localparam int                     EMPTY_MAX = (1 << EMPTY_WIDTH) - 1;

   // floor(x / 10) as (x * RECIP_TEN) >> RECIP_SHIFT, exact for 16-bit x
   localparam int RECIP_SHIFT = 19;
   localparam logic [TOTAL_WIDTH-1:0] RECIP_TEN = 16'd52429;

   typedef struct packed {
      logic signed [ACCEL_WIDTH-1:0] accel_x;
      logic signed [ACCEL_WIDTH-1:0] accel_y;
      logic signed [ACCEL_WIDTH-1:0] accel_z;
      logic [STEP_WIDTH-1:0]         step_count;
      logic [HR_WIDTH-1:0]           heart_rate;
      logic [HOUR_WIDTH-1:0]         hour_of_day;
      logic                          charging;
   } req_item_type;

   typedef struct packed {
      logic [SCALED_WIDTH-1:0] light_sleep_scaled;
      logic [SCALED_WIDTH-1:0] deep_sleep_scaled;
      logic                    clear_event;
   } rsp_item_type;

   // total * 11 / 10, truncated: total + floor(total / 10)
   function automatic logic [SCALED_WIDTH-1:0] scale_total(
      input logic [TOTAL_WIDTH-1:0] total
   );
      logic [2*TOTAL_WIDTH-1:0] prod;
      logic [TOTAL_WIDTH-1:0]   tenth;
      prod  = total * RECIP_TEN;
      tenth = TOTAL_WIDTH'(prod >> RECIP_SHIFT);
      return SCALED_WIDTH'(total) + SCALED_WIDTH'(tenth);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/wrist_sleep_stage_tracker.sv
// Wrist sleep stage tracker.
// req channel: one sensor item per second (accel x/y/z, cumulative steps,
// heart rate, hour, charging); accepted when req_valid and req_ready are high.
// rsp channel: one item per request with both sleep totals scaled by 11/10
// and a pulse flag set when this request cleared the totals.
// csr port: write-only registers, taken on any edge with csr_we high; write
// them only while no request is in flight.
// Path: an accepted request is registered in the input stage, then processed
// and written to the result register once that one is empty or taken, and
// shown on rsp from the result register.
// Throughput: one item per cycle while the result register is free;
// each state update is one pass of logic, input stage to result register.
// Reset: synchronous; all tracking state and totals clear, the registers
// take their default thresholds, both stages empty.
// Stall: when rsp_ready is low the result holds, the input stage holds one
// more item behind it, and req_ready drops once both are full.
`default_nettype none

module wrist_sleep_stage_tracker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire wsst_pkg::req_item_type                req_data,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      wsst_pkg::rsp_item_type                rsp_data,
   input  wire logic                                  csr_we,
   input  wire logic [wsst_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [wsst_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import wsst_pkg::*;

`include "wrist_sleep_stage_tracker_assert.svh"

   // configuration registers
   logic [MAG_WIDTH-1:0]         move_th_ff;
   logic [MAG_WIDTH-1:0]         activity_th_ff;
   logic [STILL_WIDTH-1:0]       light_still_ff;
   logic [STILL_WIDTH-1:0]       deep_still_ff;
   logic [STILL_WIDTH-1:0]       nonwear_still_ff;
   logic [AWAKE_LIMIT_WIDTH-1:0] awake_limit_ff;
   logic [EMPTY_WIDTH-1:0]       empty_limit_ff;

   // pipeline registers
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;
   logic         advance;
   logic         state_update;

   // tracking state
   logic [MAG_WIDTH-1:0]    prev_mag_ff, prev_mag_in;
   logic [STILL_WIDTH-1:0]  still_ff, still_in;
   logic [PHASE_WIDTH-1:0]  phase_ff, phase_in;
   logic                    walk_ff, walk_in;
   logic [STEP_WIDTH-1:0]   prev_steps_ff, prev_steps_in;
   logic [EMPTY_WIDTH-1:0]  empty_ff, empty_in;
   logic [AWAKE_WIDTH-1:0]  awake_ff, awake_in;
   logic [MOTION_HOURS-1:0] flags_ff, flags_in;
   logic [TOTAL_WIDTH-1:0]  light_ff, light_in;
   logic [TOTAL_WIDTH-1:0]  deep_ff, deep_in;
   logic                    clear_in;

   // per-item intermediates
   logic signed [SUM_WIDTH-1:0]  accel_sum;
   logic [MAG_WIDTH-1:0]         mag;
   logic [MAG_WIDTH-1:0]         diff;
   logic                         early;
   logic                         night;
   logic                         stepped;
   logic                         motion;
   logic [ZERO_COUNT_WIDTH-1:0]  zero_count;

   // handshake: result register frees when empty or taken
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !s1_valid_ff || advance;
   assign state_update = s1_valid_ff && advance;
   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   assign early = s1_data_ff.hour_of_day < MORNING_HOUR;
   assign night = early || (s1_data_ff.hour_of_day >= NIGHT_START_HOUR);

   // magnitude of the axis sum and change from the previous sample
   always_comb begin
      accel_sum = SUM_WIDTH'(s1_data_ff.accel_x) + SUM_WIDTH'(s1_data_ff.accel_y)
                + SUM_WIDTH'(s1_data_ff.accel_z);
      mag  = accel_sum[SUM_WIDTH-1] ? MAG_WIDTH'(-accel_sum) : MAG_WIDTH'(accel_sum);
      diff = (mag >= prev_mag_ff) ? (mag - prev_mag_ff) : (prev_mag_ff - mag);
   end

   // count motionless early hours
   always_comb begin
      zero_count = '0;
      for (int i = 0; i < MOTION_HOURS; i++) begin
         zero_count = zero_count + ZERO_COUNT_WIDTH'(!flags_ff[i]);
      end
   end

   // state update for the item in the input stage
   always_comb begin
      prev_mag_in   = prev_mag_ff;
      still_in      = still_ff;
      phase_in      = phase_ff;
      walk_in       = walk_ff;
      prev_steps_in = prev_steps_ff;
      empty_in      = empty_ff;
      awake_in      = awake_ff;
      flags_in      = flags_ff;
      light_in      = light_ff;
      deep_in       = deep_ff;
      clear_in      = 1'b0;
      stepped       = (prev_steps_ff < s1_data_ff.step_count) && (prev_steps_ff != '0);
      motion        = (diff >= activity_th_ff) || (s1_data_ff.heart_rate != '0);

      if (!s1_data_ff.charging) begin
         // stillness count
         if (diff >= move_th_ff) begin
            still_in = '0;
         end else if (still_ff != STILL_MAX) begin
            still_in = still_ff + 1'b1;
         end

         // early-hour motion flags
         for (int i = 0; i < MOTION_HOURS; i++) begin
            if (motion && s1_data_ff.hour_of_day == HOUR_WIDTH'(i)) begin
               flags_in[i] = 1'b1;
            end
         end

         prev_mag_in = mag;

         // minute tick
         if (phase_ff == '0) begin
            if (stepped || walk_ff) begin
               walk_in = !walk_ff || stepped;
               if (early && awake_ff != AWAKE_MAX) begin
                  awake_in = awake_ff + 1'b1;
               end
            end else if (still_in <= light_still_ff) begin
               if (early) begin
                  if (awake_ff != AWAKE_MAX) begin
                     awake_in = awake_ff + 1'b1;
                  end
               end else begin
                  awake_in = '0;
               end
            end

            if (night) begin
               if (s1_data_ff.hour_of_day >= MOTION_HOURS_HOUR &&
                   s1_data_ff.hour_of_day <= MORNING_HOUR && empty_ff == '0) begin
                  if (32'(zero_count) > EMPTY_MAX) begin
                     empty_in = EMPTY_WIDTH'(EMPTY_MAX);
                  end else begin
                     empty_in = EMPTY_WIDTH'(zero_count);
                  end
               end

               if (still_in >= nonwear_still_ff || empty_in >= empty_limit_ff ||
                   (early && awake_in > AWAKE_WIDTH'(awake_limit_ff))) begin
                  awake_in = '0;
                  light_in = '0;
                  deep_in  = '0;
                  clear_in = 1'b1;
               end else if (prev_steps_ff == s1_data_ff.step_count &&
                            still_in >= light_still_ff) begin
                  if (still_in >= deep_still_ff) begin
                     if (deep_ff != TOTAL_MAX) begin
                        deep_in = deep_ff + 1'b1;
                     end
                  end else if (light_ff != TOTAL_MAX) begin
                     light_in = light_ff + 1'b1;
                  end
               end
            end else begin
               // daytime: tracking state and totals back to reset, but for phase and steps
               prev_mag_in = '0;
               walk_in     = 1'b0;
               still_in    = '0;
               empty_in    = '0;
               deep_in     = '0;
               light_in    = '0;
               awake_in    = '0;
               flags_in    = '0;
            end
         end

         phase_in      = (phase_ff >= PHASE_LAST) ? '0 : phase_ff + 1'b1;
         prev_steps_in = s1_data_ff.step_count;
      end

      rsp_data_in.light_sleep_scaled = scale_total(light_in);
      rsp_data_in.deep_sleep_scaled  = scale_total(deep_in);
      rsp_data_in.clear_event        = clear_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         move_th_ff       <= MOVE_THRESHOLD_RESET;
         activity_th_ff   <= ACTIVITY_THRESHOLD_RESET;
         light_still_ff   <= LIGHT_STILL_RESET;
         deep_still_ff    <= DEEP_STILL_RESET;
         nonwear_still_ff <= NONWEAR_STILL_RESET;
         awake_limit_ff   <= AWAKE_LIMIT_RESET;
         empty_limit_ff   <= EMPTY_HOUR_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MOVE_THRESHOLD:     move_th_ff       <= csr_wdata;
            CSR_ACTIVITY_THRESHOLD: activity_th_ff   <= csr_wdata;
            CSR_LIGHT_STILL:        light_still_ff   <= csr_wdata[STILL_WIDTH-1:0];
            CSR_DEEP_STILL:         deep_still_ff    <= csr_wdata[STILL_WIDTH-1:0];
            CSR_NONWEAR_STILL:      nonwear_still_ff <= csr_wdata[STILL_WIDTH-1:0];
            CSR_AWAKE_LIMIT:        awake_limit_ff   <= csr_wdata[AWAKE_LIMIT_WIDTH-1:0];
            CSR_EMPTY_HOUR_LIMIT:   empty_limit_ff   <= csr_wdata[EMPTY_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (state_update) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mag_ff   <= '0;
         still_ff      <= '0;
         phase_ff      <= '0;
         walk_ff       <= 1'b0;
         prev_steps_ff <= '0;
         empty_ff      <= '0;
         awake_ff      <= '0;
         flags_ff      <= '0;
         light_ff      <= '0;
         deep_ff       <= '0;
      end else if (state_update) begin
         prev_mag_ff   <= prev_mag_in;
         still_ff      <= still_in;
         phase_ff      <= phase_in;
         walk_ff       <= walk_in;
         prev_steps_ff <= prev_steps_in;
         empty_ff      <= empty_in;
         awake_ff      <= awake_in;
         flags_ff      <= flags_in;
         light_ff      <= light_in;
         deep_ff       <= deep_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `WSST_ASSERT_ALWAYS(a_clear_zero_totals, !(rsp_valid_ff && rsp_data_ff.clear_event) || (rsp_data_ff.light_sleep_scaled == '0 && rsp_data_ff.deep_sleep_scaled == '0))
   `WSST_ASSERT_ALWAYS(a_phase_range, phase_ff <= PHASE_LAST)
   `WSST_ASSERT_NEXT(a_daytime_reset, state_update && !s1_data_ff.charging && phase_ff == '0 && !night, light_ff == '0 && deep_ff == '0 && flags_ff == '0 && awake_ff == '0)
   `WSST_ASSERT_NEXT(a_charging_holds, state_update && s1_data_ff.charging, $stable(light_ff) && $stable(still_ff) && $stable(phase_ff))

endmodule

`default_nettype wire
